FILE: src/tte_pkg.sv
// Shared types and constants of the tap tempo estimator.
// Used by the channel interfaces, the interval history and the core.
package tte_pkg;

  localparam int TS_W       = 32;
  localparam int ENC_W      = 8;
  localparam int MS_W       = 11;
  localparam int DEB_W      = 10;
  localparam int GAP_W      = 12;
  localparam int STEP_W     = 7;
  localparam int SPM_W      = 8;
  localparam int TEMPO_O_W  = 15;
  localparam int DELAY_W    = 19;
  localparam int HELD_W     = 3;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic REQ_TAP = 1'b0;
  localparam logic REQ_ENC = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ANCHOR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BOUNCE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACCEPT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ENCODER = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMPO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMPO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENC_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPM       = 3'd5;

  typedef struct packed {
    logic push;
    logic clear;
  } hist_ctrl_t;

endpackage

FILE: src/tte_if.sv
// Request and response channel interfaces of the tap tempo estimator.
// Depends on tte_pkg for the field widths.
interface tte_req_if;
  import tte_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [TS_W-1:0]         now_ms;
  logic signed [ENC_W-1:0] encoder_steps;
  modport source (output valid, req_type, now_ms, encoder_steps, input ready);
  modport sink (input valid, req_type, now_ms, encoder_steps, output ready);
endinterface

interface tte_rsp_if;
  import tte_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TEMPO_O_W-1:0] tempo_q4;
  logic [DELAY_W-1:0]   delay_samples;
  logic [HELD_W-1:0]    intervals_held;
  logic [KIND_W-1:0]    event_kind;
  modport source (output valid, tempo_q4, delay_samples, intervals_held, event_kind,
                  input ready);
  modport sink (input valid, tempo_q4, delay_samples, intervals_held, event_kind,
                output ready);
endinterface

FILE: src/tte_history.sv
// History of the most recent tap intervals with its fill count.
// Depends on tte_pkg; read by the core one entry per cycle while summing.
module tte_history #(
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tte_pkg::hist_ctrl_t            ctrl,
  input  logic [tte_pkg::GAP_W-1:0]      push_data,
  input  logic [$clog2(DEPTH)-1:0]       rd_idx,
  output logic [tte_pkg::GAP_W-1:0]      rd_data,
  output logic [$clog2(DEPTH+1)-1:0]     count
);
  import tte_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [GAP_W-1:0] store [DEPTH];
  logic             full;

  assign full    = (count == CW'(DEPTH));
  assign rd_data = store[rd_idx];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (!full) begin
        store[count[IW-1:0]] <= push_data;
      end else begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          store[i] <= store[i+1];
        end
        store[DEPTH-1] <= push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.push && !full) begin
      count <= CW'(count + 1'b1);
    end
  end

endmodule

FILE: src/tap_tempo_estimator_core.sv
// Top level of the tap tempo estimator: configuration, sequencer and shared adder.
// Depends on tte_pkg, the channel interfaces in tte_if and tte_history.
//
// Requests arrive on req, one beat per tap or encoder turn, and each gives exactly
// one beat on rsp carrying the tempo, the delay in samples, the number of intervals
// in use and the kind of event. Configuration registers are written through cfg_we,
// cfg_idx and cfg_data; the user must write them only while no request is in flight,
// as the block does not enforce it. The interval sum, the division, clamping and both
// multiplications go through one adder/subtractor under a small sequencer: the sum
// adds the held intervals one by one, the division by the count is a restoring
// divider giving one quotient bit per cycle, clamping compares with the lower bound
// and then, unless below it, with the upper bound, and both multiplications (encoder
// step and delay in samples) are shift-and-add. An anchor, restart, bounce or zero
// encoder turn goes from classification straight to the delay multiplication, an
// encoder adjustment passes the step multiplication and clamping before it, and an
// accepted interval passes the sum, the division and clamping before it. req.ready is
// high only while the sequencer is idle, so a request is accepted only once the one
// before has reached the output register. A finished response sits there, so the next
// request is accepted while rsp is stalled; its own response waits until the register
// frees. Reset restores the register defaults, a tempo of 500 ms and an empty run.
module tap_tempo_estimator_core #(
  parameter int HISTORY_DEPTH = 4,
  parameter int FRAC_BITS     = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [tte_pkg::CFG_DATA_W-1:0]   cfg_data,
  tte_req_if.sink                          req,
  tte_rsp_if.source                        rsp
);
  import tte_pkg::*;

  localparam int TW  = MS_W + FRAC_BITS;
  localparam int AW  = TW + 9;
  localparam int IW  = $clog2(HISTORY_DEPTH);
  localparam int CW  = $clog2(HISTORY_DEPTH + 1);
  localparam int RW  = IW + 1;
  localparam int SW  = GAP_W + $clog2(HISTORY_DEPTH);
  localparam int DW  = SW + FRAC_BITS;
  localparam int DCW = $clog2(DW);
  localparam int MCW = $clog2(SPM_W);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLASS = 4'd1;
  localparam logic [3:0] ST_SUM   = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_ENC   = 4'd4;
  localparam logic [3:0] ST_CLO   = 4'd5;
  localparam logic [3:0] ST_CHI   = 4'd6;
  localparam logic [3:0] ST_DINIT = 4'd7;
  localparam logic [3:0] ST_DLY   = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  logic [3:0]  state;
  logic [3:0]  state_next;

  logic [MS_W-1:0]   min_tempo;
  logic [MS_W-1:0]   max_tempo;
  logic [DEB_W-1:0]  debounce;
  logic [GAP_W-1:0]  timeout;
  logic [STEP_W-1:0] enc_step;
  logic [SPM_W-1:0]  spm;

  logic              awaiting;
  logic [TS_W-1:0]   last_tap;
  logic [TW-1:0]     tempo;
  logic              rsp_valid;

  logic                    type_r;
  logic [TS_W-1:0]         now_r;
  logic [TS_W-1:0]         gap_r;
  logic signed [ENC_W-1:0] steps_r;
  logic [KIND_W-1:0]       kind_r;
  logic signed [AW-1:0]    acc;
  logic signed [AW-1:0]    mcand;
  logic [SPM_W-1:0]        mplier;
  logic [MCW-1:0]          mcnt;
  logic [DW-1:0]           quo;
  logic [RW-1:0]           rem;
  logic [DCW-1:0]          dcnt;
  logic [CW-1:0]           sidx;

  logic [TEMPO_O_W-1:0] tempo_o;
  logic [DELAY_W-1:0]   delay_o;
  logic [HELD_W-1:0]    held_o;
  logic [KIND_W-1:0]    kind_o;

  logic signed [AW-1:0] alu_a;
  logic signed [AW-1:0] alu_b;
  logic                 alu_sub;
  logic signed [AW-1:0] alu_res;
  logic                 alu_neg;

  logic signed [AW-1:0] lo_bound;
  logic signed [AW-1:0] hi_bound;
  logic [AW-1:0]        acc_u;
  logic [RW-1:0]        shifted;
  logic                 qbit;
  logic [DW-1:0]        quo_next;

  logic                 req_fire;
  logic                 out_free;
  logic                 gap_timeout;
  logic                 gap_bounce;
  logic                 tap_anchor;
  logic                 tap_restart;
  logic                 tap_keep;
  logic                 enc_move;
  logic                 mul_last;
  logic                 sum_last;
  logic                 div_last;

  hist_ctrl_t           hctrl;
  logic [GAP_W-1:0]     hist_rd;
  logic [CW-1:0]        count;

  tte_history #(
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (hctrl),
    .push_data (gap_r[GAP_W-1:0]),
    .rd_idx    (sidx[IW-1:0]),
    .rd_data   (hist_rd),
    .count     (count)
  );

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;

  assign rsp.valid          = rsp_valid;
  assign rsp.tempo_q4       = tempo_o;
  assign rsp.delay_samples  = delay_o;
  assign rsp.intervals_held = held_o;
  assign rsp.event_kind     = kind_o;

  assign lo_bound = AW'(min_tempo) <<< FRAC_BITS;
  assign hi_bound = AW'(max_tempo) <<< FRAC_BITS;
  assign acc_u    = acc;

  assign gap_timeout = (|gap_r[TS_W-1:GAP_W]) || (gap_r[GAP_W-1:0] > timeout);
  assign gap_bounce  = !((|gap_r[TS_W-1:DEB_W]) || (gap_r[DEB_W-1:0] > debounce));

  assign tap_anchor  = (type_r == REQ_TAP) && awaiting;
  assign tap_restart = (type_r == REQ_TAP) && !awaiting && gap_timeout;
  assign tap_keep    = (type_r == REQ_TAP) && !awaiting && !gap_timeout && !gap_bounce;
  assign enc_move    = (type_r == REQ_ENC) && (steps_r != '0);

  assign hctrl.push  = (state == ST_CLASS) && tap_keep;
  assign hctrl.clear = (state == ST_CLASS) && (tap_anchor || tap_restart);

  assign mul_last = (mcnt == MCW'(SPM_W - 1));
  assign sum_last = (CW'(sidx + 1'b1) == count);
  assign div_last = (dcnt == DCW'(DW - 1));

  assign shifted  = {rem[RW-2:0], quo[DW-1]};

  always_comb begin
    alu_a   = acc;
    alu_b   = mcand;
    alu_sub = 1'b0;
    case (state)
      ST_SUM: begin
        alu_b = AW'(hist_rd);
      end
      ST_DIV: begin
        alu_a   = AW'(shifted);
        alu_b   = AW'(count);
        alu_sub = 1'b1;
      end
      ST_CLO: begin
        alu_b   = lo_bound;
        alu_sub = 1'b1;
      end
      ST_CHI: begin
        alu_a   = hi_bound;
        alu_b   = acc;
        alu_sub = 1'b1;
      end
      default: begin
        alu_b = mcand;
      end
    endcase
  end

  assign alu_res  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_neg  = alu_res[AW-1];
  assign qbit     = !alu_neg;
  assign quo_next = {quo[DW-2:0], qbit};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (tap_keep) begin
          state_next = ST_SUM;
        end else if (enc_move) begin
          state_next = ST_ENC;
        end else begin
          state_next = ST_DINIT;
        end
      end
      ST_SUM: begin
        if (sum_last) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_CLO;
        end
      end
      ST_ENC: begin
        if (mul_last) begin
          state_next = ST_CLO;
        end
      end
      ST_CLO: begin
        state_next = alu_neg ? ST_DINIT : ST_CHI;
      end
      ST_CHI: begin
        state_next = ST_DINIT;
      end
      ST_DINIT: begin
        state_next = ST_DLY;
      end
      ST_DLY: begin
        if (mul_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      min_tempo <= MS_W'(20);
      max_tempo <= MS_W'(2000);
      debounce  <= DEB_W'(50);
      timeout   <= GAP_W'(3000);
      enc_step  <= STEP_W'(5);
      spm       <= SPM_W'(48);
      awaiting  <= 1'b1;
      last_tap  <= '0;
      tempo     <= TW'(500) << FRAC_BITS;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MIN_TEMPO: min_tempo <= cfg_data[MS_W-1:0];
          CFG_MAX_TEMPO: max_tempo <= cfg_data[MS_W-1:0];
          CFG_DEBOUNCE:  debounce  <= cfg_data[DEB_W-1:0];
          CFG_TIMEOUT:   timeout   <= cfg_data[GAP_W-1:0];
          CFG_ENC_STEP:  enc_step  <= cfg_data[STEP_W-1:0];
          CFG_SPM:       spm       <= cfg_data[SPM_W-1:0];
          default: begin
          end
        endcase
      end
      if (state == ST_CLASS) begin
        if (tap_anchor) begin
          awaiting <= 1'b0;
        end
        if (tap_anchor || tap_restart || tap_keep) begin
          last_tap <= now_r;
        end
      end
      if (state == ST_CLO && alu_neg) begin
        tempo <= lo_bound[TW-1:0];
      end
      if (state == ST_CHI) begin
        tempo <= alu_neg ? hi_bound[TW-1:0] : acc[TW-1:0];
      end
      if (state == ST_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          type_r  <= req.req_type;
          now_r   <= req.now_ms;
          gap_r   <= req.now_ms - last_tap;
          steps_r <= req.encoder_steps;
        end
      end
      ST_CLASS: begin
        acc  <= '0;
        sidx <= '0;
        if (type_r == REQ_ENC) begin
          kind_r <= KIND_ENCODER;
          acc    <= AW'(tempo);
          mcand  <= AW'(steps_r) <<< FRAC_BITS;
          mplier <= SPM_W'(enc_step);
          mcnt   <= '0;
        end else if (awaiting) begin
          kind_r <= KIND_ANCHOR;
        end else if (gap_timeout) begin
          kind_r <= KIND_RESTART;
        end else if (gap_bounce) begin
          kind_r <= KIND_BOUNCE;
        end else begin
          kind_r <= KIND_ACCEPT;
        end
      end
      ST_SUM: begin
        acc  <= alu_res;
        sidx <= CW'(sidx + 1'b1);
        if (sum_last) begin
          quo  <= DW'(alu_res) << FRAC_BITS;
          rem  <= '0;
          dcnt <= '0;
        end
      end
      ST_DIV: begin
        quo  <= quo_next;
        rem  <= qbit ? alu_res[RW-1:0] : shifted;
        dcnt <= DCW'(dcnt + 1'b1);
        if (div_last) begin
          acc <= AW'(quo_next);
        end
      end
      ST_ENC, ST_DLY: begin
        if (mplier[0]) begin
          acc <= alu_res;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        mcnt   <= MCW'(mcnt + 1'b1);
      end
      ST_DINIT: begin
        acc    <= '0;
        mcand  <= AW'(tempo);
        mplier <= spm;
        mcnt   <= '0;
      end
      ST_FIN: begin
        if (out_free) begin
          tempo_o <= TEMPO_O_W'(tempo);
          delay_o <= DELAY_W'(acc_u >> FRAC_BITS);
          held_o  <= HELD_W'(count);
          kind_o  <= kind_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
